// ===== rtl/core/jsu_pkg.sv =====
// shared types, constants and helpers for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int JOB_BYTES   = 5;
  localparam int HELD_DIGITS = 3;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [5:0] {
    PH_TEXT = 6'b000001,
    PH_ESC  = 6'b000010,
    PH_U0   = 6'b000100,
    PH_U1   = 6'b001000,
    PH_U2   = 6'b010000,
    PH_U3   = 6'b100000
  } phase_t;

  // one queued job: the result bytes that one input item causes
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      empty;
    logic                      fin;
  } job_t;

  // value of a hex digit, bit 4 set when the byte is no hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] h;
    h = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      h = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h = {1'b0, c[3:0] + 4'd9};
    end
    return h;
  endfunction

endpackage

// ===== rtl/core/jsu_front.sv =====
// front end: escape state machine that turns each input item into a job
`timescale 1ns / 1ps

module jsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // in_byte
  input  logic             s_tlast,   // in_last
  input  logic             q_full,
  output logic             q_push,
  output jsu_pkg::job_t    q_job
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     code_value, code_next;
  logic            raw_pass, raw_next;
  logic [7:0]      held_digits [jsu_pkg::HELD_DIGITS];
  logic            held_we;
  logic [1:0]      k;
  logic [4:0]      hex;
  logic [15:0]     code_shift;
  logic            accept;
  logic [7:0]      b;
  jsu_pkg::job_t   job;

  assign s_tready   = !q_full;
  assign accept     = s_tvalid && s_tready;
  assign b          = s_tdata;
  assign hex        = jsu_pkg::hex_of(b);
  assign code_shift = {code_value[11:0], hex[3:0]};

  always_comb begin
    case (phase)
      jsu_pkg::PH_U1: k = 2'd1;
      jsu_pkg::PH_U2: k = 2'd2;
      jsu_pkg::PH_U3: k = 2'd3;
      default:        k = 2'd0;
    endcase
  end

  always_comb begin
    phase_next = phase;
    code_next  = code_value;
    raw_next   = raw_pass;
    held_we    = 1'b0;
    job        = '0;
    if (raw_pass) begin
      job.bytes[0] = b;
      job.count    = 3'd1;
    end else begin
      case (phase)
        jsu_pkg::PH_ESC: begin
          phase_next = jsu_pkg::PH_TEXT;
          job.count  = 3'd1;
          if (b == jsu_pkg::CH_U) begin
            job.bytes[0] = jsu_pkg::CH_U;
            if (!s_tlast) begin
              job.count  = 3'd0;
              phase_next = jsu_pkg::PH_U0;
              code_next  = '0;
            end
          end else if (b == jsu_pkg::CH_T) begin
            job.bytes[0] = jsu_pkg::CH_TAB;
          end else if (b == jsu_pkg::CH_N) begin
            job.bytes[0] = jsu_pkg::CH_LF;
          end else if (b == jsu_pkg::CH_R) begin
            job.bytes[0] = jsu_pkg::CH_CR;
          end else begin
            job.bytes[0] = b;
          end
        end
        jsu_pkg::PH_U0, jsu_pkg::PH_U1, jsu_pkg::PH_U2, jsu_pkg::PH_U3: begin
          if (!hex[4] && phase == jsu_pkg::PH_U3) begin
            phase_next = jsu_pkg::PH_TEXT;
            code_next  = '0;
            if (code_shift[15:7] == '0) begin
              job.bytes[0] = code_shift[7:0];
              job.count    = 3'd1;
            end else if (code_shift[15:11] == '0) begin
              job.bytes[0] = {3'b110, code_shift[10:6]};
              job.bytes[1] = {2'b10, code_shift[5:0]};
              job.count    = 3'd2;
            end else begin
              job.bytes[0] = {4'b1110, code_shift[15:12]};
              job.bytes[1] = {2'b10, code_shift[11:6]};
              job.bytes[2] = {2'b10, code_shift[5:0]};
              job.count    = 3'd3;
            end
          end else if (!hex[4] && !s_tlast) begin
            code_next  = code_shift;
            held_we    = 1'b1;
            phase_next = jsu_pkg::phase_t'({phase[4:0], 1'b0});
          end else begin
            // raw pass-through of the u, the digits held and this byte
            job.bytes[0] = jsu_pkg::CH_U;
            for (int i = 0; i < jsu_pkg::HELD_DIGITS; i++) begin
              job.bytes[i+1] = (i < int'(k)) ? held_digits[i] : b;
            end
            job.bytes[jsu_pkg::JOB_BYTES-1] = b;
            job.count = 3'(k) + 3'd2;
            if (hex[4]) begin
              raw_next   = 1'b1;
              phase_next = jsu_pkg::PH_TEXT;
              code_next  = '0;
            end
          end
        end
        default: begin
          phase_next = jsu_pkg::PH_TEXT;
          if (b == jsu_pkg::CH_BSL) begin
            if (!s_tlast) begin
              phase_next = jsu_pkg::PH_ESC;
            end
          end else begin
            job.bytes[0] = b;
            job.count    = 3'd1;
          end
        end
      endcase
    end
    if (s_tlast) begin
      phase_next = jsu_pkg::PH_TEXT;
      code_next  = '0;
      raw_next   = 1'b0;
      job.fin    = 1'b1;
      if (job.count == 3'd0) begin
        job.bytes[0] = jsu_pkg::CH_NUL;
        job.count    = 3'd1;
        job.empty    = 1'b1;
      end
    end
  end

  assign q_job  = job;
  assign q_push = accept && (job.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jsu_pkg::PH_TEXT;
      code_value <= '0;
      raw_pass   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      code_value <= code_next;
      raw_pass   <= raw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held_digits[k] <= b;
    end
  end

endmodule

// ===== rtl/core/jsu_queue.sv =====
// short job queue between the front end and the back end
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output jsu_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/core/jsu_back.sv =====
// back end: sends each job's bytes one item a cycle while m_tready is high, via an output register
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  jsu_pkg::job_t head_job,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // out_byte
  output logic [1:0]    m_tuser,   // byte_valid, run_last
  output logic          m_tlast    // string_end
);

  logic [2:0] idx;
  logic       load;
  logic       last_of;
  logic [7:0] sel_byte;

  assign load    = head_valid && (!m_tvalid || m_tready);
  assign last_of = (idx == head_job.count - 3'd1);
  assign pop     = load && last_of;

  always_comb begin
    case (idx)
      3'd0:    sel_byte = head_job.bytes[0];
      3'd1:    sel_byte = head_job.bytes[1];
      3'd2:    sel_byte = head_job.bytes[2];
      3'd3:    sel_byte = head_job.bytes[3];
      3'd4:    sel_byte = head_job.bytes[4];
      default: sel_byte = jsu_pkg::CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= last_of ? 3'd0 : idx + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= sel_byte;
      m_tuser <= {last_of, !head_job.empty};
      m_tlast <= last_of && head_job.fin;
    end
  end

endmodule

// ===== rtl/core/json_string_unescape_top.sv =====
// top level of the streaming json string unescaper
`timescale 1ns / 1ps

// Input stream: one raw byte of the escaped string body per item on s_tdata,
// s_tlast high on the final byte of the string.
// Output stream: one decoded byte per item on m_tdata; m_tuser[0] is low only
// for the empty end marker, m_tuser[1] marks the last item caused by one input
// byte, m_tlast marks the final item of the string.
// An input byte yields zero to five output items; a \u escape gives one to
// three UTF-8 bytes once its fourth hex digit arrives.
// The first output item of an input byte is written into the queue slot and
// then into the output register, also with an empty queue and free register.
// Throughput: one input byte per cycle while each yields at most one item and
// m_tready stays high; the output register sends one item per cycle while
// m_tready is high, so a byte that yields n items holds the output side until
// they are sent, and a queue of QUEUE_DEPTH jobs lets the input side go on.
// When the receiver stalls, the output item holds, the queue fills and then
// s_tready drops. Reset clears the escape state, empties the queue and drops
// m_tvalid; the block takes input from the first cycle after reset.

module json_string_unescape_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [1:0] m_tuser,   // byte_valid, run_last
  output logic       m_tlast    // string_end
);

  logic          q_full, q_push, q_pop, q_valid;
  jsu_pkg::job_t q_job, head_job;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  a_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("string end without run end");

  a_marker_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == jsu_pkg::CH_NUL)
    else $error("empty marker away from string end");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job queue overflow");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

// ===== tb/testbench.sv =====
// testbench for the json string unescaper: directed and random string bodies checked per item
`timescale 1ns / 1ps

module testbench;

  localparam int RAND_ITEMS  = 450;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       str_end;
  } dec_byte_t;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } raw_item_t;

  class unescaper_check;
    jsu_pkg::phase_t phase;
    logic [15:0]     code;
    logic [7:0]      held [jsu_pkg::HELD_DIGITS];
    bit              raw;
    dec_byte_t       step_q[$];
    dec_byte_t       decoded_q[$];
    int              errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = jsu_pkg::PH_TEXT;
      code  = '0;
      raw   = 1'b0;
      foreach (held[i]) held[i] = '0;
    endfunction

    static function int digit_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
      return -1;
    endfunction

    function void emit(logic [7:0] d);
      step_q.push_back('{data: d, valid: 1'b1, run_last: 1'b0, str_end: 1'b0});
    endfunction

    // broken \u: the u, the digits held so far and the current byte go out raw
    function void emit_raw_escape(int count, logic [7:0] b);
      emit(jsu_pkg::CH_U);
      for (int i = 0; i < count; i++) emit(held[i]);
      emit(b);
    endfunction

    function void take_raw_byte(logic [7:0] b, logic last);
      int h;
      int k;
      logic [15:0] v;
      step_q.delete();
      h = digit_value(b);
      case (phase)
        jsu_pkg::PH_U0: k = 0;
        jsu_pkg::PH_U1: k = 1;
        jsu_pkg::PH_U2: k = 2;
        jsu_pkg::PH_U3: k = 3;
        default:        k = -1;
      endcase
      if (raw) begin
        emit(b);
      end else if (phase == jsu_pkg::PH_ESC) begin
        phase = jsu_pkg::PH_TEXT;
        if (b == jsu_pkg::CH_U) begin
          if (last) begin
            emit(jsu_pkg::CH_U);
          end else begin
            phase = jsu_pkg::PH_U0;
            code  = '0;
          end
        end else begin
          case (b)
            jsu_pkg::CH_T: emit(jsu_pkg::CH_TAB);
            jsu_pkg::CH_N: emit(jsu_pkg::CH_LF);
            jsu_pkg::CH_R: emit(jsu_pkg::CH_CR);
            default:       emit(b);
          endcase
        end
      end else if (k >= 0) begin
        if (h >= 0) begin
          code = {code[11:0], h[3:0]};
          if (k == 3) begin
            v = code;
            if (v < 16'h0080) begin
              emit(v[7:0]);
            end else if (v < 16'h0800) begin
              emit({3'b110, v[10:6]});
              emit({2'b10, v[5:0]});
            end else begin
              emit({4'b1110, v[15:12]});
              emit({2'b10, v[11:6]});
              emit({2'b10, v[5:0]});
            end
            phase = jsu_pkg::PH_TEXT;
            code  = '0;
          end else if (last) begin
            emit_raw_escape(k, b);
          end else begin
            held[k] = b;
            phase   = jsu_pkg::phase_t'(phase << 1);
          end
        end else begin
          emit_raw_escape(k, b);
          raw   = 1'b1;
          phase = jsu_pkg::PH_TEXT;
          code  = '0;
        end
      end else begin
        phase = jsu_pkg::PH_TEXT;
        if (b == jsu_pkg::CH_BSL) begin
          if (!last) phase = jsu_pkg::PH_ESC;
        end else begin
          emit(b);
        end
      end
      if (last) begin
        if (step_q.size() == 0) begin
          step_q.push_back('{data: jsu_pkg::CH_NUL, valid: 1'b0,
                             run_last: 1'b0, str_end: 1'b0});
        end
        step_q[$].str_end = 1'b1;
        clear();
      end
      if (step_q.size() > 0) step_q[$].run_last = 1'b1;
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    endfunction

    function void match_output(logic [7:0] d, logic [1:0] user, logic fin);
      dec_byte_t want;
      dec_byte_t got;
      got = '{data: d, valid: user[0], run_last: user[1], str_end: fin};
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item byte %h valid %b run_last %b end %b",
                 $time, d, user[0], user[1], fin);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %h/%b/%b/%b actual %h/%b/%b/%b",
                 $time, want.data, want.valid, want.run_last, want.str_end,
                 got.data, got.valid, got.run_last, got.str_end);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  unescaper_check board;
  logic [7:0]     body_q[$];
  raw_item_t      raw_q[$];

  json_string_unescape_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic close_string();
    foreach (body_q[i]) raw_q.push_back('{b: body_q[i], l: (i == body_q.size() - 1)});
    body_q.delete();
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return 8'((($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + n - 10);
  endfunction

  task automatic add_hex(logic [15:0] v, int digits);
    for (int i = 0; i < digits; i++) body_q.push_back(hex_char(v[15 - 4 * i -: 4]));
  endtask

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (unescaper_check::digit_value(c) >= 0);
    return c;
  endfunction

  function automatic logic [15:0] code_point();
    logic [15:0] edges [7] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                               16'h0800, 16'hD800, 16'hFFFF};
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: return edges[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic logic [7:0] escaped_char();
    logic [7:0] picks [8] = '{jsu_pkg::CH_T, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_BSL,
                              8'h22, 8'h2F, 8'h62, 8'h66};
    logic [7:0] c;
    if ($urandom_range(0, 2) != 0) return picks[$urandom_range(0, 7)];
    c = 8'($urandom_range(0, 255));
    return (c == jsu_pkg::CH_U) ? jsu_pkg::CH_BSL : c;
  endfunction

  task automatic add_random_string();
    int kind;
    logic [7:0] c;
    repeat ($urandom_range(1, 8)) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        c = 8'($urandom_range(0, 255));
        body_q.push_back((c == jsu_pkg::CH_BSL) ? 8'h5B : c);
      end else if (kind < 58) begin
        body_q.push_back(jsu_pkg::CH_BSL);
        body_q.push_back(escaped_char());
      end else if (kind < 85) begin
        add_text("\\u");
        add_hex(code_point(), 4);
      end else if (kind < 94) begin
        add_text("\\u");
        add_hex(16'($urandom), $urandom_range(0, 3));
        body_q.push_back(non_hex_byte());
      end else begin
        repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // odd endings: lone backslash, cut-off \u, broken \u on the last byte
    case ($urandom_range(0, 9))
      0: body_q.push_back(jsu_pkg::CH_BSL);
      1: begin
        add_text("\\u");
        add_hex(16'($urandom), $urandom_range(0, 3));
      end
      2: begin
        add_text("\\u");
        add_hex(16'($urandom), $urandom_range(0, 3));
        body_q.push_back(non_hex_byte());
      end
      default: ;
    endcase
    close_string();
  endtask

  task automatic build_stimulus();
    int directed;
    body_q.push_back(8'h00);
    add_text("\\t\\n\\r\\\"");
    body_q.push_back(8'hFF);
    close_string();
    add_text("\\uFfF0");
    close_string();
    add_text("\\u0gx");
    close_string();
    add_text("\\");
    close_string();
    add_text("\\u1");
    close_string();
    directed = raw_q.size();
    while (raw_q.size() < directed + RAND_ITEMS) add_random_string();
  endtask

  // gaps come in stretches, some of them with no idling at all
  task automatic draw_gap(inout int left, inout bit calm, output int gap);
    if (left == 0) begin
      left = $urandom_range(10, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    gap = calm ? 0 : $urandom_range(0, 14);
  endtask

  task automatic send_item(raw_item_t it, int gap, bit drain);
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      while (drain && board.decoded_q.size() != 0) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.b;
    s_tlast  <= it.l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_raw_byte(it.b, it.l);
    @(negedge clk);
  endtask

  initial begin
    int gap;
    int left;
    bit calm;
    board    = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    left     = 0;
    calm     = 1'b0;
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (raw_q[i]) begin
      draw_gap(left, calm, gap);
      send_item(raw_q[i], gap, i == raw_q.size() / 2);
    end
    s_tvalid <= 1'b0;
    while (board.decoded_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (board.errors == 0) begin
      $display("[json_string_unescape_top] OK");
    end else begin
      $display("[json_string_unescape_top] ERROR");
    end
    $finish;
  end

  initial begin
    int gap;
    int left;
    int seen;
    bit calm;
    bit held_long;
    m_tready  = 1'b0;
    left      = 0;
    seen      = 0;
    calm      = 1'b0;
    held_long = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      draw_gap(left, calm, gap);
      // one long hold so the queue fills and the input side stalls
      if (!held_long && seen >= 100) begin
        gap       = LONG_HOLD;
        held_long = 1'b1;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.match_output(m_tdata, m_tuser, m_tlast);
      seen++;
      @(negedge clk);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[json_string_unescape_top] ERROR");
        $finish;
      end
    end
  end

endmodule
